FILE: src/fab_pkg.sv
`timescale 1ns / 1ps
// types, status codes and bitmap helpers for the frame bitmap allocator
// no dependencies

package fab_pkg;

  typedef logic [63:0] map_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_ZERO_REQ  = 3'd2,
    ST_ZERO_FREE = 3'd3,
    ST_UNALIGNED = 3'd4,
    ST_MISMATCH  = 3'd5,
    ST_IDENTITY  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_FREE_CHK,
    S_DONE
  } state_e;

  // header part plus ceil(bytes / 8) data parts plus one
  function automatic logic [5:0] parts_for(logic [7:0] bytes);
    return 6'd2 + {1'b0, bytes[7:3]} + {5'b0, |bytes[2:0]};
  endfunction

  function automatic map_t run_mask(logic [5:0] parts);
    return (map_t'(1) << parts) - map_t'(1);
  endfunction

  // bit s (never bit 0) set when parts bits starting at s are clear and fit below bit 64
  function automatic map_t fit_vec(map_t bm, logic [5:0] parts);
    logic [64:0] w;
    logic [64:0] acc;
    map_t        fit;
    w   = {1'b0, ~bm};
    acc = '1;
    for (int b = 0; b < 6; b++) begin
      if (parts[b]) begin
        acc = w & (acc >> (1 << b));
      end
      w = w & (w >> (1 << b));
    end
    fit    = acc[63:0];
    fit[0] = 1'b0;
    return fit;
  endfunction

  function automatic logic [5:0] lowest_set(map_t v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: src/fab_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module fab_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// frame bitmap allocator: first-fit small-object allocation and free over
// per-frame 64-bit occupancy maps; depends on fab_pkg and fab_ram
//
// Usage:
//   Input words (action, request_size, user_pointer, stored_size) and result
//   words (status, result_pointer, frame_index, start_part) move on valid/ready
//   channels. One word in gives exactly one result word.
//   Allocate reads one frame map per cycle from the bitmap ram in frame order,
//   through a two-stage fit pipeline. A request that fits stops the scan at the
//   first frame with a fitting run, one that runs out of memory stops at the
//   last frame, and one that meets a lost map bit stops at that frame. A zero
//   request goes straight to its result; a free does one ram read-modify-write.
//   One word is in work at a time; input ready is high only while the block is
//   idle.
//   After reset the block walks the ram once, writing the empty map to every
//   frame, with input ready low meanwhile.
//   The result sits in an output register; the next word is taken while it
//   waits, and that word's result holds in the block until the receiver
//   takes the previous one.

module frame_bitmap_allocator_top #(
  parameter int unsigned NUM_FRAMES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  request_size_i,
  input  logic [16:0] user_pointer_i,
  input  logic [7:0]  stored_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [16:0] result_pointer_o,
  output logic [7:0]  frame_index_o,
  output logic [5:0]  start_part_o
);

  localparam int unsigned FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);

  fab_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    iss_q, iss_d;
  logic             v1_q, v1_d;
  logic [FW-1:0]    f1_q, f1_d;
  logic             v2_q, v2_d;
  logic [FW-1:0]    f2_q, f2_d;
  fab_pkg::map_t    fit2_q, fit2_d;
  logic             id2_q, id2_d;
  fab_pkg::map_t    bm2_q, bm2_d;
  logic [5:0]       parts_q, parts_d;
  logic [7:0]       ssize_q, ssize_d;
  logic [FW-1:0]    sel_f_q, sel_f_d;
  logic [5:0]       sel_s_q, sel_s_d;
  fab_pkg::map_t    sel_bm_q, sel_bm_d;
  fab_pkg::status_e res_status_q, res_status_d;
  logic [16:0]      res_ptr_q, res_ptr_d;
  logic [7:0]       res_frame_q, res_frame_d;
  logic [5:0]       res_part_q, res_part_d;
  logic             out_valid_q, out_valid_d;
  fab_pkg::status_e out_status_q, out_status_d;
  logic [16:0]      out_ptr_q, out_ptr_d;
  logic [7:0]       out_frame_q, out_frame_d;
  logic [5:0]       out_part_q, out_part_d;

  logic             ram_we;
  logic [FW-1:0]    ram_waddr;
  fab_pkg::map_t    ram_wdata;
  logic [FW-1:0]    ram_raddr;
  fab_pkg::map_t    ram_rdata;

  logic             issue;
  logic             stop;
  logic [16:0]      hdr;
  fab_pkg::map_t    commit_mask;
  fab_pkg::map_t    free_mask;

  fab_ram #(
    .Width (64),
    .Depth (NUM_FRAMES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign hdr         = user_pointer_i - 17'd2;
  assign commit_mask = fab_pkg::run_mask(parts_q) << sel_s_q;
  assign free_mask   = fab_pkg::run_mask(fab_pkg::parts_for(ssize_q)) << sel_s_q;
  assign issue       = (iss_q < CW'(NUM_FRAMES));

  always_comb begin
    state_d      = state_q;
    iss_d        = iss_q;
    v1_d         = 1'b0;
    f1_d         = iss_q[FW-1:0];
    v2_d         = 1'b0;
    f2_d         = f1_q;
    fit2_d       = fab_pkg::fit_vec(ram_rdata, parts_q);
    id2_d        = ram_rdata[0];
    bm2_d        = ram_rdata;
    parts_d      = parts_q;
    ssize_d      = ssize_q;
    sel_f_d      = sel_f_q;
    sel_s_d      = sel_s_q;
    sel_bm_d     = sel_bm_q;
    res_status_d = res_status_q;
    res_ptr_d    = res_ptr_q;
    res_frame_d  = res_frame_q;
    res_part_d   = res_part_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_status_d = out_status_q;
    out_ptr_d    = out_ptr_q;
    out_frame_d  = out_frame_q;
    out_part_d   = out_part_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = iss_q[FW-1:0];
    in_ready_o   = 1'b0;
    stop         = 1'b0;

    unique case (state_q)
      fab_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = iss_q[FW-1:0];
        ram_wdata = fab_pkg::map_t'(1);
        iss_d     = iss_q + CW'(1);
        if (iss_q == CW'(NUM_FRAMES - 1)) begin
          state_d = fab_pkg::S_IDLE;
        end
      end
      fab_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!action_i) begin
            res_ptr_d   = '0;
            res_frame_d = '0;
            res_part_d  = '0;
            if (request_size_i == 8'd0) begin
              res_status_d = fab_pkg::ST_ZERO_REQ;
              state_d      = fab_pkg::S_DONE;
            end else begin
              parts_d = fab_pkg::parts_for(request_size_i);
              iss_d   = '0;
              state_d = fab_pkg::S_SCAN;
            end
          end else begin
            res_ptr_d   = '0;
            res_frame_d = hdr[16:9];
            res_part_d  = hdr[8:3];
            ssize_d     = stored_size_i;
            sel_f_d     = FW'(hdr[16:9]);
            sel_s_d     = hdr[8:3];
            ram_raddr   = FW'(hdr[16:9]);
            if (stored_size_i == 8'd0) begin
              res_status_d = fab_pkg::ST_ZERO_FREE;
              state_d      = fab_pkg::S_DONE;
            end else if (hdr[2:0] != 3'd0) begin
              res_status_d = fab_pkg::ST_UNALIGNED;
              state_d      = fab_pkg::S_DONE;
            end else if (32'(hdr[16:9]) >= NUM_FRAMES) begin
              res_status_d = fab_pkg::ST_MISMATCH;
              state_d      = fab_pkg::S_DONE;
            end else begin
              state_d = fab_pkg::S_FREE_CHK;
            end
          end
        end
      end
      fab_pkg::S_SCAN: begin
        if (v2_q) begin
          if (!id2_q) begin
            stop         = 1'b1;
            res_status_d = fab_pkg::ST_IDENTITY;
            res_frame_d  = 8'(f2_q);
            state_d      = fab_pkg::S_DONE;
          end else if (|fit2_q) begin
            stop     = 1'b1;
            sel_f_d  = f2_q;
            sel_s_d  = fab_pkg::lowest_set(fit2_q);
            sel_bm_d = bm2_q;
            state_d  = fab_pkg::S_COMMIT;
          end else if (f2_q == FW'(NUM_FRAMES - 1)) begin
            stop         = 1'b1;
            res_status_d = fab_pkg::ST_OOM;
            state_d      = fab_pkg::S_DONE;
          end
        end
        v1_d = issue & ~stop;
        v2_d = v1_q & ~stop;
        if (issue) begin
          iss_d = iss_q + CW'(1);
        end
      end
      fab_pkg::S_COMMIT: begin
        ram_we       = 1'b1;
        ram_waddr    = sel_f_q;
        ram_wdata    = sel_bm_q | commit_mask;
        res_status_d = fab_pkg::ST_OK;
        res_ptr_d    = {8'(sel_f_q), sel_s_q, 3'b010};
        res_frame_d  = 8'(sel_f_q);
        res_part_d   = sel_s_q;
        state_d      = fab_pkg::S_DONE;
      end
      fab_pkg::S_FREE_CHK: begin
        if ((ram_rdata & free_mask) == free_mask) begin
          ram_we       = 1'b1;
          ram_waddr    = sel_f_q;
          ram_wdata    = ram_rdata & ~free_mask;
          res_status_d = fab_pkg::ST_OK;
        end else begin
          res_status_d = fab_pkg::ST_MISMATCH;
        end
        state_d = fab_pkg::S_DONE;
      end
      fab_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_ptr_d    = res_ptr_q;
          out_frame_d  = res_frame_q;
          out_part_d   = res_part_q;
          state_d      = fab_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fab_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fab_pkg::S_CLEAR;
      iss_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q         <= f1_d;
    f2_q         <= f2_d;
    fit2_q       <= fit2_d;
    id2_q        <= id2_d;
    bm2_q        <= bm2_d;
    parts_q      <= parts_d;
    ssize_q      <= ssize_d;
    sel_f_q      <= sel_f_d;
    sel_s_q      <= sel_s_d;
    sel_bm_q     <= sel_bm_d;
    res_status_q <= res_status_d;
    res_ptr_q    <= res_ptr_d;
    res_frame_q  <= res_frame_d;
    res_part_q   <= res_part_d;
    out_status_q <= out_status_d;
    out_ptr_q    <= out_ptr_d;
    out_frame_q  <= out_frame_d;
    out_part_q   <= out_part_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign result_pointer_o = out_ptr_q;
  assign frame_index_o    = out_frame_q;
  assign start_part_o     = out_part_q;

  // a committed run lands on clear bits of an intact map, past the map part
  a_commit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fab_pkg::S_COMMIT |->
      ((sel_bm_q & commit_mask) == '0) && sel_bm_q[0] && (sel_s_q != 6'd0))
    else $error("allocation commit overlaps used parts");

  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || v2_q) |-> state_q == fab_pkg::S_SCAN)
    else $error("scan pipeline active outside scan");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == fab_pkg::S_CLEAR || state_q == fab_pkg::S_COMMIT ||
                state_q == fab_pkg::S_FREE_CHK))
    else $error("bitmap ram written in unexpected state");

endmodule
